// ----- hdl/ansisgr_pkg.sv -----
// ---------------------------------------------------------------------------
// ANSI SGR colour parser package
// Shared types, byte codes, register indexes and the 16-entry colour palette.
// ---------------------------------------------------------------------------
package ansisgr_pkg;

	typedef enum logic [2:0] {
		PH_TEXT,
		PH_ESC,
		PH_PARAM,
		PH_MODE,
		PH_INDEX,
		PH_RED,
		PH_GREEN,
		PH_BLUE
	} phase_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_END    = 8'h6D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_FG = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_BG = 1'b1;

	localparam logic [23:0] RESET_FG = 24'hFFFFFF;
	localparam logic [23:0] RESET_BG = 24'h000000;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0]  char_code;
		logic [23:0] fg;
		logic [23:0] bg;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	function automatic logic [23:0] palette(input logic [3:0] idx);
		logic [23:0] colour;
		unique case (idx)
			4'd0:    colour = 24'h000000;
			4'd1:    colour = 24'hAA0000;
			4'd2:    colour = 24'h00AA00;
			4'd3:    colour = 24'hAA5500;
			4'd4:    colour = 24'h0000AA;
			4'd5:    colour = 24'hAA00AA;
			4'd6:    colour = 24'h00AAAA;
			4'd7:    colour = 24'hAAAAAA;
			4'd8:    colour = 24'h555555;
			4'd9:    colour = 24'hFF5555;
			4'd10:   colour = 24'h55FF55;
			4'd11:   colour = 24'hFFFF55;
			4'd12:   colour = 24'h5555FF;
			4'd13:   colour = 24'hFF55FF;
			4'd14:   colour = 24'h55FFFF;
			default: colour = 24'hFFFFFF;
		endcase
		return colour;
	endfunction

endpackage

// ----- hdl/ansisgr_step.sv -----
// ---------------------------------------------------------------------------
// ANSI SGR parser step
// Holds the parse state and colours; turns one byte into up to two results.
// ---------------------------------------------------------------------------
module ansisgr_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [7:0]           text_byte,
	input  logic [23:0]          default_fg,
	input  logic [23:0]          default_bg,
	output ansisgr_pkg::push_t   push
);

	ansisgr_pkg::phase_t phase_q, phase_d;
	logic [15:0] acc_q, acc_d;
	logic        ext_bg_q, ext_bg_d;
	logic [7:0]  red_q, red_d;
	logic [7:0]  green_q, green_d;
	logic [23:0] fg_q, fg_d;
	logic [23:0] bg_q, bg_d;

	logic        is_digit, is_semi, is_end;
	logic [3:0]  digit;
	logic [19:0] acc_mul;
	logic [15:0] acc_next;
	logic [7:0]  acc_sat8;
	logic [1:0]  n;
	logic [7:0]  ch0;
	logic        last0;
	logic        set_en;
	logic [23:0] set_val;

	assign is_digit = (text_byte >= ansisgr_pkg::CH_ZERO) && (text_byte <= ansisgr_pkg::CH_NINE);
	assign is_semi  = text_byte == ansisgr_pkg::CH_SEMI;
	assign is_end   = (text_byte == ansisgr_pkg::CH_END) || (text_byte == ansisgr_pkg::CH_NUL);
	assign digit    = 4'(text_byte - ansisgr_pkg::CH_ZERO);
	assign acc_mul  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {16'h0000, digit};
	assign acc_next = (acc_mul > 20'd65535) ? 16'hFFFF : acc_mul[15:0];
	assign acc_sat8 = (acc_q > 16'd255) ? 8'hFF : acc_q[7:0];

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		ext_bg_d = ext_bg_q;
		red_d   = red_q;
		green_d = green_q;
		fg_d    = fg_q;
		bg_d    = bg_q;
		n       = 2'd0;
		ch0     = text_byte;
		last0   = 1'b1;
		set_en  = 1'b0;
		set_val = 24'h000000;
		unique case (phase_q)
			ansisgr_pkg::PH_TEXT: begin
				if (text_byte == ansisgr_pkg::CH_ESC) begin
					phase_d = ansisgr_pkg::PH_ESC;
				end else if (text_byte != ansisgr_pkg::CH_NUL) begin
					n = 2'd1;
				end
			end
			ansisgr_pkg::PH_ESC: begin
				if (text_byte == ansisgr_pkg::CH_LBRACK) begin
					phase_d = ansisgr_pkg::PH_PARAM;
					acc_d   = 16'h0000;
				end else if (text_byte == ansisgr_pkg::CH_ESC) begin
					n   = 2'd1;
					ch0 = ansisgr_pkg::CH_ESC;
				end else begin
					phase_d = ansisgr_pkg::PH_TEXT;
					ch0     = ansisgr_pkg::CH_ESC;
					if (text_byte == ansisgr_pkg::CH_NUL) begin
						n = 2'd1;
					end else begin
						n     = 2'd2;
						last0 = 1'b0;
					end
				end
			end
			default: begin
				if (is_digit) begin
					acc_d = acc_next;
				end else if (!is_semi && !is_end) begin
					phase_d = ansisgr_pkg::PH_TEXT;
					acc_d   = 16'h0000;
				end else begin
					unique case (phase_q)
						ansisgr_pkg::PH_PARAM: begin
							if (is_semi && (acc_q == 16'd38 || acc_q == 16'd48)) begin
								ext_bg_d = acc_q == 16'd48;
								phase_d  = ansisgr_pkg::PH_MODE;
							end else if (acc_q == 16'd0) begin
								fg_d = default_fg;
								bg_d = default_bg;
							end else if (acc_q >= 16'd30 && acc_q <= 16'd37) begin
								fg_d = ansisgr_pkg::palette(4'(acc_q - 16'd30));
							end else if (acc_q >= 16'd40 && acc_q <= 16'd47) begin
								bg_d = ansisgr_pkg::palette(4'(acc_q - 16'd40));
							end else if (acc_q >= 16'd90 && acc_q <= 16'd97) begin
								fg_d = ansisgr_pkg::palette(4'(acc_q - 16'd82));
							end else if (acc_q >= 16'd100 && acc_q <= 16'd107) begin
								bg_d = ansisgr_pkg::palette(4'(acc_q - 16'd92));
							end else if (acc_q == 16'd39) begin
								fg_d = default_fg;
							end else if (acc_q == 16'd49) begin
								bg_d = default_bg;
							end
						end
						ansisgr_pkg::PH_MODE: begin
							if (acc_q == 16'd2) begin
								if (is_semi) begin
									phase_d = ansisgr_pkg::PH_RED;
								end else begin
									set_en = 1'b1;
								end
							end else if (acc_q == 16'd5 && is_semi) begin
								phase_d = ansisgr_pkg::PH_INDEX;
							end else begin
								phase_d = ansisgr_pkg::PH_PARAM;
							end
						end
						ansisgr_pkg::PH_INDEX: begin
							if (acc_q < 16'd16) begin
								set_en  = 1'b1;
								set_val = ansisgr_pkg::palette(acc_q[3:0]);
							end
							phase_d = ansisgr_pkg::PH_PARAM;
						end
						ansisgr_pkg::PH_RED: begin
							red_d   = acc_sat8;
							green_d = 8'h00;
							if (is_semi) begin
								phase_d = ansisgr_pkg::PH_GREEN;
							end else begin
								set_en  = 1'b1;
								set_val = {acc_sat8, 16'h0000};
							end
						end
						ansisgr_pkg::PH_GREEN: begin
							green_d = acc_sat8;
							if (is_semi) begin
								phase_d = ansisgr_pkg::PH_BLUE;
							end else begin
								set_en  = 1'b1;
								set_val = {red_q, acc_sat8, 8'h00};
							end
						end
						default: begin
							set_en  = 1'b1;
							set_val = {red_q, green_q, acc_sat8};
							phase_d = ansisgr_pkg::PH_PARAM;
						end
					endcase
					acc_d = 16'h0000;
					if (is_end) begin
						phase_d = ansisgr_pkg::PH_TEXT;
					end
				end
			end
		endcase
		if (set_en) begin
			if (ext_bg_q) begin
				bg_d = set_val;
			end else begin
				fg_d = set_val;
			end
		end
	end

	assign push.count  = go ? n : 2'd0;
	assign push.first  = '{char_code: ch0, fg: fg_q, bg: bg_q, last: last0};
	assign push.second = '{char_code: text_byte, fg: fg_q, bg: bg_q, last: 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ansisgr_pkg::PH_TEXT;
			acc_q    <= 16'h0000;
			ext_bg_q <= 1'b0;
			red_q    <= 8'h00;
			green_q  <= 8'h00;
			fg_q     <= ansisgr_pkg::RESET_FG;
			bg_q     <= ansisgr_pkg::RESET_BG;
		end else if (go) begin
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			ext_bg_q <= ext_bg_d;
			red_q    <= red_d;
			green_q  <= green_d;
			fg_q     <= fg_d;
			bg_q     <= bg_d;
		end
	end

`ifndef SYNTH
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> !push.first.last && push.second.last)
		else $error("two-result beat pair out of order");

	a_text_holds: assert property (@(posedge clk) disable iff (!arst_n)
		go && phase_q == ansisgr_pkg::PH_TEXT && text_byte != ansisgr_pkg::CH_ESC
		|=> phase_q == ansisgr_pkg::PH_TEXT)
		else $error("text phase left without escape");
`endif

endmodule

// ----- hdl/ansisgr_queue.sv -----
// ---------------------------------------------------------------------------
// ANSI SGR result queue
// Small queue taking up to two results a cycle and giving one beat a cycle unless stalled.
// ---------------------------------------------------------------------------
module ansisgr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ansisgr_pkg::push_t   push,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ansisgr_pkg::result_t head
);

	ansisgr_pkg::result_t entries [ansisgr_pkg::QDEPTH];
	logic [ansisgr_pkg::QPTR_W-1:0] head_q, tail_q;
	logic [ansisgr_pkg::QCNT_W-1:0] count_q;
	logic                           pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;
	assign room      = count_q <= ansisgr_pkg::QCNT_W'(ansisgr_pkg::QDEPTH - 2);
	assign head      = entries[head_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entries[tail_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entries[tail_q + ansisgr_pkg::QPTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + ansisgr_pkg::QPTR_W'(push.count);
			head_q  <= head_q + ansisgr_pkg::QPTR_W'(pop);
			count_q <= count_q + ansisgr_pkg::QCNT_W'(push.count)
				- ansisgr_pkg::QCNT_W'(pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ansisgr_pkg::QCNT_W'(ansisgr_pkg::QDEPTH))
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> room)
		else $error("push into result queue without room");
`endif

endmodule

// ----- hdl/ansi_sgr_color_parser.sv -----
// ---------------------------------------------------------------------------
// ANSI SGR colour parser
// Text byte stream in, coloured characters out, SGR colour sequences parsed.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall / text_byte) takes one byte a beat.
// Output channel (out_valid / out_stall) gives one character a beat with its
// 24-bit foreground and background; last_of_run marks the final character
// caused by one input byte (an ESC followed by a byte other than '[', ESC or NUL gives two).
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) sets
// the default colours; cfg_ready is always high. Write only while idle.
// Each input byte is registered, then its results are written into the result queue.
// Throughput: one byte a cycle while the queue has room and each byte gives
// at most one character; a byte giving two characters slows the output, set
// by the single read port of the four-entry result queue.
// Reset: parser in text phase, colours white on black, defaults likewise.
// When the receiver stalls, the result queue fills and in_stall rises
// once fewer than two entries are free; no beat is lost.
// ---------------------------------------------------------------------------
module ansi_sgr_color_parser (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [7:0]                            text_byte,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [7:0]                            char_code,
	output logic [23:0]                           fg_color,
	output logic [23:0]                           bg_color,
	output logic                                  last_of_run,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ansisgr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [23:0]                           cfg_data
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 room;
	logic                 go;
	logic [23:0]          default_fg_q;
	logic [23:0]          default_bg_q;
	ansisgr_pkg::push_t   push;
	ansisgr_pkg::result_t head;

	assign go        = valid_s1 && room;
	assign in_stall  = valid_s1 && !room;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_fg_q <= ansisgr_pkg::RESET_FG;
			default_bg_q <= ansisgr_pkg::RESET_BG;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ansisgr_pkg::CFG_DEFAULT_FG: default_fg_q <= cfg_data;
				default:                     default_bg_q <= cfg_data;
			endcase
		end
	end

	ansisgr_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.text_byte  (byte_s1),
		.default_fg (default_fg_q),
		.default_bg (default_bg_q),
		.push       (push)
	);

	ansisgr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign char_code   = head.char_code;
	assign fg_color    = head.fg;
	assign bg_color    = head.bg;
	assign last_of_run = head.last;

endmodule
